// ===== hw/rtl/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg
// shared constants, codes and types of the link flit packer
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_BYTES = 64;
    localparam int HEADER_BYTES  = 16;
    localparam int ID_BITS       = 16;
    localparam int MAX_RESULTS   = 32;

    localparam int IDX_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int HDR_PACK_MAX = (PAYLOAD_BYTES > HEADER_BYTES)
                                  ? (PAYLOAD_BYTES - HEADER_BYTES) / HEADER_BYTES : 0;
    localparam int KW           = $clog2(HDR_PACK_MAX + 4);

    localparam logic [1:0] REQ_ENQ      = 2'd0;
    localparam logic [1:0] REQ_DRAIN_DN = 2'd1;
    localparam logic [1:0] REQ_DRAIN_UP = 2'd2;

    // low bit of the message kind as kept in a queue entry
    localparam logic KIND_PLAIN = 1'b0;
    localparam logic KIND_ALT   = 1'b1;

    localparam logic [2:0] FT_H4 = 3'd0;
    localparam logic [2:0] FT_H5 = 3'd1;
    localparam logic [2:0] FT_G0 = 3'd2;
    localparam logic [2:0] FT_G4 = 3'd3;
    localparam logic [2:0] FT_G5 = 3'd4;
    localparam logic [2:0] FT_G6 = 3'd5;

    typedef struct packed {
        logic               kind;
        logic [ID_BITS-1:0] id;
    } entry_t;

    typedef struct packed {
        logic             push;
        entry_t           wdata;
        logic             del;
        logic [IDX_W-1:0] del_idx;
        logic [IDX_W-1:0] rd_idx;
    } qcmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        entry_t           head;
        entry_t           rd;
    } qstat_t;

    function automatic logic [6:0] slot_bytes(input int unsigned slots);
        int unsigned b;
        b = HEADER_BYTES * slots;
        if (b > PAYLOAD_BYTES)
        begin
            b = PAYLOAD_BYTES;
        end
        return 7'(b);
    endfunction

endpackage

// ===== hw/rtl/lfp_queue.sv =====
// ----------------------------------------------------------------------------
// lfp_queue
// message queue with push at the tail, delete at any index and one read port
// ----------------------------------------------------------------------------
module lfp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  lfp_pkg::qcmd_t cmd,
    output lfp_pkg::qstat_t stat
);
    import lfp_pkg::*;

    entry_t           q_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            q_reg[count_reg[IDX_W-1:0]] <= cmd.wdata;
        end
        else if (cmd.del)
        begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++)
            begin
                if (j >= int'(cmd.del_idx))
                begin
                    q_reg[j] <= q_reg[j+1];
                end
            end
        end
    end

    assign stat.count = count_reg;
    assign stat.head  = q_reg[0];
    assign stat.rd    = q_reg[cmd.rd_idx];

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> count_reg < CNT_W'(QUEUE_DEPTH))
        else $error("push into full queue");

    a_del_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |-> (!cmd.push && CNT_W'(cmd.del_idx) < count_reg))
        else $error("delete outside queued entries");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance count");

endmodule

// ===== hw/rtl/link_flit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// link_flit_packer_unit
// packs queued link messages of two directions into flits on a drain item
// ----------------------------------------------------------------------------
// An enqueue item is pushed in the cycle that accepts it; a drop on a full
// queue gives one result item through the drop state. A drain runs through
// one sequencer and one delete/read port per queue: the accepting cycle, one
// head check per flit group and one at the end, the removal of each message
// (on the down queue the head removal shares the head check), the emission
// of each flit, and the examination of each entry when a data response at
// the head looks for a queued no-data response and when a data-response
// flit gathers no-data responses from within the queue. On the up queue
// every data response at the head scans the rest of the queue again, and
// stalled results hold the sequencer. The input is stalled while a drain or
// a drop is in progress.
// ----------------------------------------------------------------------------
module link_flit_packer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [1:0]                  msg_kind,
    input  logic [15:0]                 message_id,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic                        direction,
    output logic [2:0]                  flit_type,
    output logic [6:0]                  bytes_used,
    output logic [6:0]                  bytes_spare,
    output logic [1:0]                  completion_count,
    output logic [15:0]                 completion_id_a,
    output logic [15:0]                 completion_id_b,
    output logic                        last
);
    import lfp_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DROP    = 4'd1;
    localparam logic [3:0] ST_D_HEAD  = 4'd2;
    localparam logic [3:0] ST_D_PACK  = 4'd3;
    localparam logic [3:0] ST_D_G0    = 4'd4;
    localparam logic [3:0] ST_U_HEAD  = 4'd5;
    localparam logic [3:0] ST_U_SRCH  = 4'd6;
    localparam logic [3:0] ST_U_G4    = 4'd7;
    localparam logic [3:0] ST_U_G4G0  = 4'd8;
    localparam logic [3:0] ST_U_G6    = 4'd9;
    localparam logic [3:0] ST_U_G6G0  = 4'd10;
    localparam logic [3:0] ST_U_G5    = 4'd11;

    localparam logic [RES_W:0] LIM = (RES_W + 1)'(MAX_RESULTS);

    logic [3:0]         state_reg, state_next;
    logic               dir_reg, dir_next;
    logic [RES_W-1:0]   n_reg, n_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               wd_reg, wd_next;
    logic [ID_BITS-1:0] head_id_reg, head_id_next;
    logic [ID_BITS-1:0] id_reg [4];
    logic               id_wr;
    logic [ID_BITS-1:0] id_wdata;

    qcmd_t  q_cmd, dn_cmd, up_cmd;
    qstat_t dn_stat, up_stat, cur;
    logic   cmd_dir;

    logic               out_valid_reg;
    logic               status_reg, direction_reg, last_reg;
    logic [2:0]         flit_type_reg;
    logic [6:0]         used_reg, wasted_reg;
    logic [1:0]         ccount_reg;
    logic [ID_BITS-1:0] ida_reg, idb_reg;

    logic               can_emit, emit_en;
    logic               e_status, e_last;
    logic [2:0]         e_type;
    logic [6:0]         e_used, e_wasted;
    logic [1:0]         e_count;
    logic [ID_BITS-1:0] e_a, e_b;

    logic               a_ok, b_ok;
    logic [1:0]         p_count;
    logic [ID_BITS-1:0] p_a, p_b;
    logic [RES_W:0]     n_inc;
    logic               enq_full;
    logic [ID_BITS-1:0] g6_id;

    lfp_queue u_dn_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dn_cmd),
        .stat  (dn_stat)
    );

    lfp_queue u_up_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (up_cmd),
        .stat  (up_stat)
    );

    assign cur      = dir_reg ? up_stat : dn_stat;
    assign dn_cmd   = (cmd_dir == 1'b0) ? q_cmd : '0;
    assign up_cmd   = (cmd_dir == 1'b1) ? q_cmd : '0;
    assign can_emit = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign n_inc    = {1'b0, n_reg} + (RES_W + 1)'(1);
    assign enq_full = (msg_kind[1] ? up_stat.count : dn_stat.count)
                      >= CNT_W'(QUEUE_DEPTH);
    assign g6_id    = id_reg[idx_reg[1:0]];

    // packed no-data ids with zero ids skipped
    always_comb
    begin
        a_ok    = (k_reg >= KW'(1)) && (id_reg[0] != '0);
        b_ok    = (k_reg >= KW'(2)) && (id_reg[1] != '0);
        p_count = 2'(a_ok) + 2'(b_ok);
        p_a     = a_ok ? id_reg[0] : (b_ok ? id_reg[1] : '0);
        p_b     = (a_ok && b_ok) ? id_reg[1] : '0;
    end

    always_comb
    begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        wd_next      = wd_reg;
        head_id_next = head_id_reg;
        id_wr        = 1'b0;
        id_wdata     = cur.head.id;
        cmd_dir      = dir_reg;
        q_cmd        = '0;
        q_cmd.rd_idx = idx_reg[IDX_W-1:0];
        emit_en      = 1'b0;
        e_status     = 1'b0;
        e_last       = 1'b0;
        e_type       = FT_H4;
        e_used       = '0;
        e_wasted     = '0;
        e_count      = '0;
        e_a          = '0;
        e_b          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_ENQ:
                        begin
                            dir_next = msg_kind[1];
                            if (enq_full)
                            begin
                                state_next = ST_DROP;
                            end
                            else
                            begin
                                cmd_dir             = msg_kind[1];
                                q_cmd.push          = 1'b1;
                                q_cmd.wdata.kind    = msg_kind[0];
                                q_cmd.wdata.id      = message_id[ID_BITS-1:0];
                            end
                        end
                        REQ_DRAIN_DN:
                        begin
                            dir_next   = 1'b0;
                            n_next     = '0;
                            state_next = ST_D_HEAD;
                        end
                        REQ_DRAIN_UP:
                        begin
                            dir_next   = 1'b1;
                            n_next     = '0;
                            state_next = ST_U_HEAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DROP:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_status   = 1'b1;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_D_HEAD:
            begin
                if (cur.count == '0 || ({1'b0, n_reg} + (RES_W + 1)'(2)) > LIM)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    wd_next       = cur.head.kind;
                    q_cmd.del     = 1'b1;
                    q_cmd.del_idx = '0;
                    k_next        = '0;
                    state_next    = ST_D_PACK;
                end
            end

            ST_D_PACK:
            begin
                if (cur.count != '0 && cur.head.kind == KIND_PLAIN &&
                    int'(k_reg) < HDR_PACK_MAX)
                begin
                    q_cmd.del     = 1'b1;
                    q_cmd.del_idx = '0;
                    k_next        = k_reg + KW'(1);
                end
                else if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_type     = wd_reg ? FT_H4 : FT_H5;
                    e_used     = slot_bytes(int'(k_reg) + 1);
                    e_wasted   = 7'(PAYLOAD_BYTES) - e_used;
                    e_last     = !wd_reg &&
                                 (cur.count == '0 || (n_inc + (RES_W + 1)'(2)) > LIM);
                    n_next     = n_inc[RES_W-1:0];
                    state_next = wd_reg ? ST_D_G0 : ST_D_HEAD;
                end
            end

            ST_D_G0:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_type     = FT_G0;
                    e_used     = 7'(PAYLOAD_BYTES - 2);
                    e_wasted   = 7'd2;
                    e_last     = cur.count == '0 || (n_inc + (RES_W + 1)'(2)) > LIM;
                    n_next     = n_inc[RES_W-1:0];
                    state_next = ST_D_HEAD;
                end
            end

            ST_U_HEAD:
            begin
                k_next = '0;
                if (cur.count == '0 || ({1'b0, n_reg} + (RES_W + 1)'(4)) > LIM)
                begin
                    state_next = ST_IDLE;
                end
                else if (cur.head.kind == KIND_PLAIN)
                begin
                    idx_next   = CNT_W'(1);
                    state_next = ST_U_SRCH;
                end
                else
                begin
                    state_next = ST_U_G5;
                end
            end

            ST_U_SRCH:
            begin
                if (idx_reg >= cur.count)
                begin
                    state_next = ST_U_G6;
                end
                else if (cur.rd.kind == KIND_ALT)
                begin
                    head_id_next  = cur.head.id;
                    q_cmd.del     = 1'b1;
                    q_cmd.del_idx = '0;
                    idx_next      = '0;
                    state_next    = ST_U_G4;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_U_G4:
            begin
                if (idx_reg < cur.count && k_reg < KW'(2))
                begin
                    if (cur.rd.kind == KIND_ALT)
                    begin
                        id_wr         = 1'b1;
                        id_wdata      = cur.rd.id;
                        q_cmd.del     = 1'b1;
                        q_cmd.del_idx = idx_reg[IDX_W-1:0];
                        k_next        = k_reg + KW'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_type     = FT_G4;
                    e_used     = slot_bytes(int'(k_reg) + 1);
                    e_wasted   = 7'(PAYLOAD_BYTES) - e_used;
                    e_count    = p_count;
                    e_a        = p_a;
                    e_b        = p_b;
                    n_next     = n_inc[RES_W-1:0];
                    state_next = ST_U_G4G0;
                end
            end

            ST_U_G4G0:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_type     = FT_G0;
                    e_used     = 7'(PAYLOAD_BYTES - 2);
                    e_wasted   = 7'd2;
                    e_count    = (head_id_reg != '0) ? 2'd1 : 2'd0;
                    e_a        = head_id_reg;
                    e_last     = cur.count == '0 || (n_inc + (RES_W + 1)'(4)) > LIM;
                    n_next     = n_inc[RES_W-1:0];
                    state_next = ST_U_HEAD;
                end
            end

            ST_U_G6:
            begin
                if (cur.count != '0 && cur.head.kind == KIND_PLAIN && k_reg < KW'(3))
                begin
                    id_wr         = 1'b1;
                    q_cmd.del     = 1'b1;
                    q_cmd.del_idx = '0;
                    k_next        = k_reg + KW'(1);
                end
                else if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_type     = FT_G6;
                    e_used     = slot_bytes(int'(k_reg));
                    e_wasted   = 7'(PAYLOAD_BYTES) - e_used;
                    n_next     = n_inc[RES_W-1:0];
                    idx_next   = '0;
                    state_next = ST_U_G6G0;
                end
            end

            ST_U_G6G0:
            begin
                if (can_emit)
                begin
                    emit_en  = 1'b1;
                    e_type   = FT_G0;
                    e_used   = 7'(PAYLOAD_BYTES - 2);
                    e_wasted = 7'd2;
                    e_count  = (g6_id != '0) ? 2'd1 : 2'd0;
                    e_a      = g6_id;
                    n_next   = n_inc[RES_W-1:0];
                    idx_next = idx_reg + CNT_W'(1);
                    if ((idx_reg[1:0] + 2'd1) == k_reg[1:0])
                    begin
                        e_last     = cur.count == '0 || (n_inc + (RES_W + 1)'(4)) > LIM;
                        state_next = ST_U_HEAD;
                    end
                end
            end

            ST_U_G5:
            begin
                if (cur.count != '0 && cur.head.kind == KIND_ALT && k_reg < KW'(2))
                begin
                    id_wr         = 1'b1;
                    q_cmd.del     = 1'b1;
                    q_cmd.del_idx = '0;
                    k_next        = k_reg + KW'(1);
                end
                else if (can_emit)
                begin
                    emit_en    = 1'b1;
                    e_type     = FT_G5;
                    e_used     = slot_bytes(int'(k_reg));
                    e_wasted   = 7'(PAYLOAD_BYTES) - e_used;
                    e_count    = p_count;
                    e_a        = p_a;
                    e_b        = p_b;
                    e_last     = cur.count == '0 || (n_inc + (RES_W + 1)'(4)) > LIM;
                    n_next     = n_inc[RES_W-1:0];
                    state_next = ST_U_HEAD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            wd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            wd_reg        <= wd_next;
            out_valid_reg <= emit_en || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        head_id_reg <= head_id_next;
        if (id_wr)
        begin
            id_reg[k_reg[1:0]] <= id_wdata;
        end
        if (emit_en)
        begin
            status_reg    <= e_status;
            direction_reg <= dir_reg;
            flit_type_reg <= e_type;
            used_reg      <= e_used;
            wasted_reg    <= e_wasted;
            ccount_reg    <= e_count;
            ida_reg       <= e_a;
            idb_reg       <= e_b;
            last_reg      <= e_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign direction        = direction_reg;
    assign flit_type        = flit_type_reg;
    assign bytes_used       = used_reg;
    assign bytes_spare      = wasted_reg;
    assign completion_count = ccount_reg;
    assign completion_id_a  = 16'(ida_reg);
    assign completion_id_b  = 16'(idb_reg);
    assign last             = last_reg;

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && e_last) |=> (state_reg == ST_IDLE || state_reg == ST_D_HEAD ||
                                 state_reg == ST_U_HEAD))
        else $error("sequencer busy after final result");

    a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && e_status) |-> (e_last && e_count == 2'd0 && e_used == '0))
        else $error("malformed drop result");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for link_flit_packer_unit: an in-bench model of the two
// message queues predicts every flit of each drain and every drop on a full
// queue, a monitor checks each result item against it field by field, and
// the input and result channels idle and stall at random
// ----------------------------------------------------------------------------
module tb;

    import lfp_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] MSG_REQ  = 2'd0;
    localparam logic [1:0] MSG_RWD  = 2'd1;
    localparam logic [1:0] MSG_DRSP = 2'd2;
    localparam logic [1:0] MSG_NDR  = 2'd3;

    localparam logic DIR_DOWN = 1'b0;
    localparam logic DIR_UP   = 1'b1;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 150;
    localparam int RANDOM_ITEMS = 245;

    typedef enum int
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } stall_mode_e;

    typedef struct packed
    {
        logic        status;
        logic        direction;
        logic [2:0]  flit_type;
        logic [6:0]  bytes_used;
        logic [6:0]  bytes_spare;
        logic [1:0]  completion_count;
        logic [15:0] completion_id_a;
        logic [15:0] completion_id_b;
        logic        last;
    } flit_t;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type         = 2'd0;
    logic [1:0]  msg_kind         = 2'd0;
    logic [15:0] message_id       = 16'd0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic        status;
    logic        direction;
    logic [2:0]  flit_type;
    logic [6:0]  bytes_used;
    logic [6:0]  bytes_spare;
    logic [1:0]  completion_count;
    logic [15:0] completion_id_a;
    logic [15:0] completion_id_b;
    logic        last;

    entry_t down_msgs[$];
    entry_t up_msgs[$];
    flit_t  flits_due[$];

    int          errors      = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          gap_max     = 8;
    int          idle_cycles = 0;
    int          hold_cnt    = 0;
    int          mode_left   = 0;
    int          beat_phase  = 0;
    logic        hold_req    = 1'b0;
    stall_mode_e stall_mode  = STALL_NONE;

    link_flit_packer_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .msg_kind         (msg_kind),
        .message_id       (message_id),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .direction        (direction),
        .flit_type        (flit_type),
        .bytes_used       (bytes_used),
        .bytes_spare      (bytes_spare),
        .completion_count (completion_count),
        .completion_id_a  (completion_id_a),
        .completion_id_b  (completion_id_b),
        .last             (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic flit_t make_flit(input logic dir, input logic [2:0] ft,
                                        input int unsigned used, input logic [1:0] nc,
                                        input logic [15:0] id_a, input logic [15:0] id_b);
        flit_t       f;
        int unsigned u;
        u = (used > PAYLOAD_BYTES) ? PAYLOAD_BYTES : used;
        f = '0;
        f.direction        = dir;
        f.flit_type        = ft;
        f.bytes_used       = 7'(u);
        f.bytes_spare      = 7'(PAYLOAD_BYTES - u);
        f.completion_count = nc;
        f.completion_id_a  = id_a;
        f.completion_id_b  = id_b;
        return f;
    endfunction

    function automatic flit_t data_flit(input logic dir, input logic [15:0] id);
        return make_flit(dir, FT_G0, PAYLOAD_BYTES - 2, (id != 16'd0) ? 2'd1 : 2'd0,
                         id, 16'd0);
    endfunction

    // zero ids complete nothing and are left out of the list
    function automatic flit_t response_flit(input logic [2:0] ft, input int unsigned slots,
                                            input logic [15:0] ids [3], input int k);
        logic [15:0] v [2];
        int          c;
        v[0] = 16'd0;
        v[1] = 16'd0;
        c = 0;
        for (int i = 0; i < k && i < 2; i++)
        begin
            if (ids[i] != 16'd0)
            begin
                v[c] = ids[i];
                c++;
            end
        end
        return make_flit(DIR_UP, ft, HEADER_BYTES * slots, 2'(c), v[0], v[1]);
    endfunction

    function automatic void pack_down(input int start);
        entry_t e;
        logic   with_data;
        int     extra;
        while (down_msgs.size() > 0 && flits_due.size() - start + 2 <= MAX_RESULTS)
        begin
            e = down_msgs[0];
            down_msgs.delete(0);
            with_data = e.kind;
            extra = 0;
            while (down_msgs.size() > 0 && down_msgs[0].kind == KIND_PLAIN
                   && extra < HDR_PACK_MAX)
            begin
                down_msgs.delete(0);
                extra++;
            end
            flits_due = {flits_due, make_flit(DIR_DOWN, with_data ? FT_H4 : FT_H5,
                                              HEADER_BYTES * (1 + extra), 2'd0,
                                              16'd0, 16'd0)};
            if (with_data)
            begin
                flits_due = {flits_due, data_flit(DIR_DOWN, 16'd0)};
            end
        end
    endfunction

    function automatic void pack_up(input int start);
        logic [15:0] ids [3];
        logic [15:0] head_id;
        logic        has_ndr;
        entry_t      e;
        int          k;
        int          i;
        while (up_msgs.size() > 0 && flits_due.size() - start + 4 <= MAX_RESULTS)
        begin
            ids[0] = 16'd0;
            ids[1] = 16'd0;
            ids[2] = 16'd0;
            k = 0;
            if (up_msgs[0].kind == KIND_PLAIN)
            begin
                head_id = 16'(up_msgs[0].id);
                has_ndr = 1'b0;
                for (i = 1; i < up_msgs.size(); i++)
                begin
                    if (up_msgs[i].kind == KIND_ALT)
                    begin
                        has_ndr = 1'b1;
                    end
                end
                if (has_ndr)
                begin
                    up_msgs.delete(0);
                    i = 0;
                    while (i < up_msgs.size() && k < 2)
                    begin
                        if (up_msgs[i].kind == KIND_ALT)
                        begin
                            ids[k] = 16'(up_msgs[i].id);
                            k++;
                            up_msgs.delete(i);
                        end
                        else
                        begin
                            i++;
                        end
                    end
                    flits_due = {flits_due, response_flit(FT_G4, 1 + k, ids, k)};
                    flits_due = {flits_due, data_flit(DIR_UP, head_id)};
                end
                else
                begin
                    while (up_msgs.size() > 0 && up_msgs[0].kind == KIND_PLAIN && k < 3)
                    begin
                        e = up_msgs[0];
                        up_msgs.delete(0);
                        ids[k] = 16'(e.id);
                        k++;
                    end
                    flits_due = {flits_due, make_flit(DIR_UP, FT_G6, HEADER_BYTES * k,
                                                      2'd0, 16'd0, 16'd0)};
                    for (i = 0; i < k; i++)
                    begin
                        flits_due = {flits_due, data_flit(DIR_UP, ids[i])};
                    end
                end
            end
            else
            begin
                while (up_msgs.size() > 0 && up_msgs[0].kind == KIND_ALT && k < 2)
                begin
                    e = up_msgs[0];
                    up_msgs.delete(0);
                    ids[k] = 16'(e.id);
                    k++;
                end
                flits_due = {flits_due, response_flit(FT_G5, k, ids, k)};
            end
        end
    endfunction

    function automatic void predict_item(input logic [1:0] rt, input logic [1:0] mk,
                                         input logic [15:0] id);
        int     start;
        entry_t e;
        flit_t  f;
        start = flits_due.size();
        if (rt == REQ_ENQ)
        begin
            e.kind = mk[0];
            e.id   = ID_BITS'(id);
            if ((mk[1] ? up_msgs.size() : down_msgs.size()) >= QUEUE_DEPTH)
            begin
                f = '0;
                f.status    = 1'b1;
                f.direction = mk[1];
                flits_due = {flits_due, f};
            end
            else if (mk[1])
            begin
                up_msgs = {up_msgs, e};
            end
            else
            begin
                down_msgs = {down_msgs, e};
            end
        end
        else if (rt == REQ_DRAIN_DN)
        begin
            pack_down(start);
        end
        else if (rt == REQ_DRAIN_UP)
        begin
            pack_up(start);
        end
        if (flits_due.size() > start)
        begin
            f = flits_due[flits_due.size() - 1];
            f.last = 1'b1;
            flits_due[flits_due.size() - 1] = f;
        end
    endfunction

    function automatic string diff_fields(input flit_t got, input flit_t want);
        string s;
        s = "";
        if (got.status !== want.status)                     s = {s, " status"};
        if (got.direction !== want.direction)               s = {s, " direction"};
        if (got.flit_type !== want.flit_type)               s = {s, " flit_type"};
        if (got.bytes_used !== want.bytes_used)             s = {s, " bytes_used"};
        if (got.bytes_spare !== want.bytes_spare)           s = {s, " bytes_spare"};
        if (got.completion_count !== want.completion_count) s = {s, " completion_count"};
        if (got.completion_id_a !== want.completion_id_a)   s = {s, " completion_id_a"};
        if (got.completion_id_b !== want.completion_id_b)   s = {s, " completion_id_b"};
        if (got.last !== want.last)                         s = {s, " last"};
        return s;
    endfunction

    task automatic report_mismatch(input string what, input flit_t got, input flit_t want);
        errors++;
        if (errors <= 40)
        begin
            $display("ERROR @%0t %s: got %h want %h", $realtime, what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        flit_t got;
        flit_t want;
        string diffs;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, direction, flit_type, bytes_used, bytes_spare,
                   completion_count, completion_id_a, completion_id_b, last};
            if (flits_due.size() == 0)
            begin
                report_mismatch("unexpected result item", got, '0);
            end
            else
            begin
                want = flits_due[0];
                flits_due.delete(0);
                diffs = diff_fields(got, want);
                if (diffs != "")
                begin
                    report_mismatch({"field mismatch:", diffs}, got, want);
                end
            end
        end
    end

    // result side stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
                default:
                begin
                    beat_phase++;
                    out_stall <= ((beat_phase % 5) < 2);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("link_flit_packer_unit: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] rt, input logic [1:0] mk,
                             input logic [15:0] id);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        req_type   <= rt;
        msg_kind   <= mk;
        message_id <= id;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_item(rt, mk, id);
        items_sent++;
    endtask

    function automatic logic [15:0] random_id();
        case ($urandom_range(0, 15))
            0, 1:    return 16'd0;
            2:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] random_kind(input logic up);
        if (up)
        begin
            return $urandom_range(0, 1) ? MSG_DRSP : MSG_NDR;
        end
        return ($urandom_range(0, 9) < 7) ? MSG_REQ : MSG_RWD;
    endfunction

    task automatic test_edge_cases();
        gap_max = 4;
        send_item(REQ_DRAIN_DN, MSG_REQ, 16'd0);
        send_item(REQ_DRAIN_UP, MSG_NDR, 16'hffff);
        send_item(REQ_NONE, MSG_NDR, 16'hffff);
        send_item(REQ_ENQ, MSG_NDR, 16'd0);
        send_item(REQ_ENQ, MSG_DRSP, 16'hffff);
        send_item(REQ_ENQ, MSG_NDR, 16'h8001);
        send_item(REQ_DRAIN_UP, MSG_DRSP, 16'd0);
        send_item(REQ_ENQ, MSG_REQ, 16'h0001);
        send_item(REQ_ENQ, MSG_REQ, 16'h0002);
        send_item(REQ_ENQ, MSG_RWD, 16'hffff);
        send_item(REQ_DRAIN_DN, MSG_RWD, 16'hffff);
    endtask

    // sixteen requests with data give the largest drain
    task automatic test_full_queue();
        gap_max = 2;
        repeat (QUEUE_DEPTH)
        begin
            send_item(REQ_ENQ, MSG_RWD, random_id());
        end
        send_item(REQ_ENQ, MSG_REQ, 16'h5a5a);
        send_item(REQ_DRAIN_DN, MSG_REQ, 16'd0);
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        hold_req = 1'b1;
        repeat (QUEUE_DEPTH + 2)
        begin
            send_item(REQ_ENQ, random_kind(DIR_UP), random_id());
        end
        send_item(REQ_DRAIN_UP, MSG_DRSP, 16'd0);
        repeat (QUEUE_DEPTH + 2)
        begin
            send_item(REQ_ENQ, random_kind(DIR_DOWN), random_id());
        end
        send_item(REQ_DRAIN_DN, MSG_REQ, 16'd0);
        send_item(REQ_DRAIN_UP, MSG_NDR, 16'd0);
    endtask

    task automatic test_random();
        int          target;
        int          k;
        logic        up;
        logic        push_drain;
        logic [1:0]  mk;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), random_id());
            end
            else
            begin
                up = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0)
                begin
                    k = $urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 3);
                    push_drain = 1'b0;
                end
                else
                begin
                    k = $urandom_range(1, 8);
                    push_drain = ($urandom_range(0, 3) == 0);
                end
                repeat (k)
                begin
                    mk = ($urandom_range(0, 9) == 0) ? random_kind(!up) : random_kind(up);
                    send_item(REQ_ENQ, mk, random_id());
                    if (push_drain && $urandom_range(0, 1))
                    begin
                        send_item(up ? REQ_DRAIN_UP : REQ_DRAIN_DN, random_kind(up),
                                  random_id());
                    end
                end
                send_item(up ? REQ_DRAIN_UP : REQ_DRAIN_DN, random_kind(up), random_id());
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(up ? REQ_DRAIN_DN : REQ_DRAIN_UP, random_kind(!up),
                              random_id());
                end
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_edge_cases();
        test_full_queue();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (flits_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
        if (errors == 0)
        begin
            $display("link_flit_packer_unit: match");
        end
        else
        begin
            $display("link_flit_packer_unit: mismatch");
        end
        $finish;
    end

endmodule
